[sv/smb_pkg.sv]
package smb_pkg;

  localparam int SEG_BYTES        = 4096;
  localparam int NUM_SEGMENTS     = 5;
  localparam int MAX_ACCESS_BYTES = 4;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 32;
  localparam int NB_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int TOP_OUT_W = 13;
  localparam int RD_BYTES  = 4;

  localparam int SEL_LSB = 20;
  localparam int SEL_W   = 4;
  localparam int OFS_W   = 20;

  localparam int LANES       = (MAX_ACCESS_BYTES > 4) ? 8 : 4;
  localparam int LANE_W      = $clog2(LANES);
  localparam int STORE_BYTES = NUM_SEGMENTS * SEG_BYTES;
  localparam int ROWS        = (STORE_BYTES + LANES - 1) / LANES;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int BADDR_W     = $clog2(STORE_BYTES + LANES);
  localparam int TOP_W       = $clog2(SEG_BYTES + 1);
  localparam int SEG_IDX_W   = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BOUNDS = 2'd1,
    STAT_BADSEG = 2'd2
  } status_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  typedef struct packed {
    status_t                       status;
    logic                          ok;
    logic                          is_write;
    logic [SEG_IDX_W-1:0]          seg;
    logic [TOP_W-1:0]              end_ofs;
    logic [LANE_W-1:0]             lane0;
    logic [NB_W-1:0]               nbytes;
    logic [LANES-1:0]              lane_en;
    logic [LANES-1:0][ROW_W-1:0]   lane_row;
    logic [LANES-1:0][7:0]         lane_data;
  } dec_t;

endpackage

[sv/smb_if.sv]
interface smb_in_if import smb_pkg::*;;
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] address;
  logic [NB_W-1:0]   access_bytes;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, command, address, access_bytes, write_data, input ready);
  modport sink   (input valid, command, address, access_bytes, write_data, output ready);
endinterface

interface smb_out_if import smb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    read_data;
  logic [STATUS_W-1:0]  status;
  logic [TOP_OUT_W-1:0] top_offset;

  modport source (output valid, read_data, status, top_offset, input ready);
  modport sink   (input valid, read_data, status, top_offset, output ready);
endinterface

[sv/smb_ram.sv]
module smb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/smb_decode.sv]
module smb_decode import smb_pkg::*; (
  input  logic              command,
  input  logic [ADDR_W-1:0] address,
  input  logic [NB_W-1:0]   access_bytes,
  input  logic [DATA_W-1:0] write_data,
  output dec_t              dec
);

  logic [SEL_W-1:0]   sel;
  logic [OFS_W-1:0]   ofs;
  logic [OFS_W:0]     end_full;
  logic               bad_seg;
  logic               bad_size;
  logic               oob;
  logic [SEL_W-1:0]   seg_full;
  logic [BADDR_W-1:0] base;
  logic [ROW_W-1:0]   row0;
  logic [LANE_W-1:0]  k [LANES];

  always_comb begin
    sel      = address[SEL_LSB +: SEL_W];
    ofs      = address[OFS_W-1:0];
    end_full = {1'b0, ofs} + (OFS_W+1)'(access_bytes);
    bad_seg  = (sel == '0) || (sel > SEL_W'(NUM_SEGMENTS));
    bad_size = (access_bytes == '0) || (access_bytes > NB_W'(MAX_ACCESS_BYTES));
    oob      = end_full > (OFS_W+1)'(SEG_BYTES);
    seg_full = sel - SEL_W'(1);
    base     = BADDR_W'(seg_full * SEG_BYTES) + BADDR_W'(ofs);
    row0     = ROW_W'(base >> LANE_W);

    if (bad_seg) begin
      dec.status = STAT_BADSEG;
    end else if (bad_size || oob) begin
      dec.status = STAT_BOUNDS;
    end else begin
      dec.status = STAT_OK;
    end
    dec.ok       = (dec.status == STAT_OK);
    dec.is_write = (command == CMD_WRITE);
    dec.seg      = bad_seg ? '0 : SEG_IDX_W'(seg_full);
    dec.end_ofs  = TOP_W'(end_full);
    dec.lane0    = base[LANE_W-1:0];
    dec.nbytes   = access_bytes;

    for (int l = 0; l < LANES; l++) begin
      k[l]             = LANE_W'(l) - dec.lane0;
      dec.lane_en[l]   = dec.ok && ((NB_W+LANE_W)'(k[l]) < (NB_W+LANE_W)'(access_bytes));
      dec.lane_row[l]  = (LANE_W'(l) < dec.lane0) ? row0 + ROW_W'(1) : row0;
      dec.lane_data[l] = ((LANE_W+1)'(k[l]) < (LANE_W+1)'(RD_BYTES)) ?
                         8'(write_data >> {k[l], 3'b000}) : 8'h00;
    end
  end

endmodule

[sv/segmented_memory_with_bounds.sv]
// Words pass a pending then an output register, one word per cycle while out_ch is ready.
// The byte store sits in byte-lane RAMs, so an unaligned access reads or writes its lanes once.
// Segment tops live in flip-flops and are updated in the cycle a write is accepted.
// After reset a clearing pass zeroes one row of all lanes per cycle, covering all ROWS rows
// (5120 with the default segment layout), and no word is accepted until it ends.
module segmented_memory_with_bounds import smb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  smb_in_if.sink     in_ch,
  smb_out_if.source  out_ch
);

  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  clr_cnt_r, clr_cnt_nxt;

  dec_t              dec;
  logic              accept;
  logic              pend_move;

  logic [TOP_W-1:0]  tops_r [NUM_SEGMENTS];
  logic [TOP_W-1:0]  cur_top;
  logic [TOP_W-1:0]  new_top;

  logic              pend_r;
  logic              pend_read_r;
  logic [LANE_W-1:0] pend_lane0_r;
  logic [NB_W-1:0]   pend_nbytes_r;
  status_t           pend_status_r;
  logic [TOP_W-1:0]  pend_top_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_rdata_r;
  status_t           out_status_r;
  logic [TOP_W-1:0]  out_top_r;

  logic [7:0]        ram_q [LANES];
  logic [DATA_W-1:0] rdata_asm;

  smb_decode u_decode (
    .command      (in_ch.command),
    .address      (in_ch.address),
    .access_bytes (in_ch.access_bytes),
    .write_data   (in_ch.write_data),
    .dec          (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ROW_W'(ROWS - 1)) begin
          state_nxt   = ST_RUN;
          clr_cnt_nxt = '0;
        end else begin
          clr_cnt_nxt = clr_cnt_r + ROW_W'(1);
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign pend_move    = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = (state_r == ST_RUN) && (!pend_r || pend_move);
  assign accept       = in_ch.valid && in_ch.ready;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;

    always_comb begin
      if (state_r == ST_CLEAR) begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wdata = 8'h00;
      end else begin
        we    = accept && dec.is_write && dec.lane_en[l];
        waddr = dec.lane_row[l];
        wdata = dec.lane_data[l];
      end
      re = accept && !dec.is_write && dec.lane_en[l];
    end

    smb_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (dec.lane_row[l]),
      .rdata (ram_q[l])
    );
  end

  always_comb begin
    cur_top = tops_r[dec.seg];
    if (dec.ok && dec.is_write && (dec.end_ofs > cur_top)) begin
      new_top = dec.end_ofs;
    end else begin
      new_top = cur_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SEGMENTS; s++) begin
        tops_r[s] <= '0;
      end
    end else if (accept) begin
      tops_r[dec.seg] <= new_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (accept) begin
      pend_r <= 1'b1;
    end else if (pend_move) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_read_r   <= dec.ok && !dec.is_write;
      pend_lane0_r  <= dec.lane0;
      pend_nbytes_r <= dec.nbytes;
      pend_status_r <= dec.status;
      pend_top_r    <= (dec.status == STAT_BADSEG) ? '0 : new_top;
    end
  end

  always_comb begin
    rdata_asm = '0;
    for (int k = 0; k < RD_BYTES; k++) begin
      if (pend_read_r && ((NB_W+1)'(k) < (NB_W+1)'(pend_nbytes_r))) begin
        rdata_asm[8*k +: 8] = ram_q[LANE_W'(pend_lane0_r + LANE_W'(k))];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_rdata_r  <= rdata_asm;
      out_status_r <= pend_status_r;
      out_top_r    <= pend_top_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_rdata_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.top_offset = TOP_OUT_W'(out_top_r);

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready)
    else $error("word accepted during the clearing pass");

  a_accept_fills_pend: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pend_r)
    else $error("accepted word did not reach the pending stage");

  a_stalled_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !pend_move) |=> (pend_r && $stable(pend_status_r)))
    else $error("pending word lost while the output was stalled");

  a_badseg_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_BADSEG)) |-> (out_top_r == '0 && out_rdata_r == '0))
    else $error("invalid segment result carries data or a top");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && dec.is_write) |=> !pend_read_r)
    else $error("write marked as a read in the pending stage");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import smb_pkg::*;

  typedef struct {
    logic              command;
    logic [ADDR_W-1:0] address;
    logic [NB_W-1:0]   access_bytes;
    logic [DATA_W-1:0] write_data;
  } access_t;

  typedef struct {
    logic [DATA_W-1:0]    read_data;
    status_t              status;
    logic [TOP_OUT_W-1:0] top_offset;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  smb_in_if  in_ch ();
  smb_out_if out_ch ();

  segmented_memory_with_bounds dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0]  shadow_bytes [NUM_SEGMENTS*SEG_BYTES];
  int unsigned shadow_tops  [NUM_SEGMENTS];

  access_t pending_words [$];
  reply_t  expected_replies [$];
  int      error_count;
  int      reply_index;

  int          burst_left;
  int          gap_left;
  logic [15:0] ready_pattern;
  int          ready_tick;
  access_t     next_word;
  reply_t      wanted;

  always begin
    #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: reply %0d: %s", $time, reply_index, msg);
    error_count++;
  endtask

  // Applies one access to the shadow store and returns the reply it must produce.
  function automatic reply_t service_access(input access_t a);
    reply_t      r;
    int unsigned sel;
    int unsigned ofs;
    int unsigned seg;
    int unsigned end_ofs;
    int unsigned idx;
    r.read_data  = '0;
    r.status     = STAT_OK;
    r.top_offset = '0;
    sel = a.address[SEL_LSB +: SEL_W];
    ofs = a.address[OFS_W-1:0];
    if (sel < 1 || sel > NUM_SEGMENTS) begin
      r.status = STAT_BADSEG;
      return r;
    end
    seg = sel - 1;
    end_ofs = ofs + a.access_bytes;
    if (a.access_bytes < 1 || a.access_bytes > MAX_ACCESS_BYTES || end_ofs > SEG_BYTES) begin
      r.status = STAT_BOUNDS;
    end else begin
      for (int k = 0; k < a.access_bytes; k++) begin
        idx = seg * SEG_BYTES + ofs + k;
        if (a.command == CMD_WRITE) begin
          shadow_bytes[idx] = (k < RD_BYTES) ? a.write_data[8*k +: 8] : 8'h00;
        end else if (k < RD_BYTES) begin
          r.read_data[8*k +: 8] = shadow_bytes[idx];
        end
      end
      if (a.command == CMD_WRITE && end_ofs > shadow_tops[seg]) begin
        shadow_tops[seg] = end_ofs;
      end
    end
    r.top_offset = shadow_tops[seg][TOP_OUT_W-1:0];
    return r;
  endfunction

  function automatic access_t make_access(input logic cmd, input int unsigned sel,
                                          input int unsigned ofs, input int unsigned nbytes,
                                          input logic [DATA_W-1:0] wdata,
                                          input logic [7:0] high_bits = 8'h00);
    access_t a;
    a.command      = cmd;
    a.address      = {high_bits, sel[SEL_W-1:0], ofs[OFS_W-1:0]};
    a.access_bytes = nbytes[NB_W-1:0];
    a.write_data   = wdata;
    return a;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.command      <= CMD_READ;
      in_ch.address      <= '0;
      in_ch.access_bytes <= '0;
      in_ch.write_data   <= '0;
      burst_left = $urandom_range(1, 48);
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        next_word.command      = in_ch.command;
        next_word.address      = in_ch.address;
        next_word.access_bytes = in_ch.access_bytes;
        next_word.write_data   = in_ch.write_data;
        expected_replies.push_back(service_access(next_word));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.command      <= next_word.command;
          in_ch.address      <= next_word.address;
          in_ch.access_bytes <= next_word.access_bytes;
          in_ch.write_data   <= next_word.write_data;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_pattern = 16'hFFFF;
      ready_tick    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected word read_data=%h status=%0d top=%0d",
                                    out_ch.read_data, out_ch.status, out_ch.top_offset));
        end else begin
          wanted = expected_replies.pop_front();
          if (out_ch.read_data !== wanted.read_data) begin
            report_mismatch($sformatf("read_data %h, expected %h",
                                      out_ch.read_data, wanted.read_data));
          end
          if (out_ch.status !== wanted.status) begin
            report_mismatch($sformatf("status %0d, expected %s",
                                      out_ch.status, wanted.status.name()));
          end
          if (out_ch.top_offset !== wanted.top_offset) begin
            report_mismatch($sformatf("top_offset %0d, expected %0d",
                                      out_ch.top_offset, wanted.top_offset));
          end
        end
        reply_index++;
      end
      ready_tick++;
      if (ready_tick % 200 == 0) begin
        ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end
      ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      out_ch.ready <= ready_pattern[0];
    end
  end

  initial begin
    int unsigned pick;
    int unsigned ofs;
    access_t     a;
    error_count = 0;
    reply_index = 0;
    for (int i = 0; i < NUM_SEGMENTS*SEG_BYTES; i++) begin
      shadow_bytes[i] = 8'h00;
    end
    for (int s = 0; s < NUM_SEGMENTS; s++) begin
      shadow_tops[s] = 0;
    end
    rst_n = 1'b0;

    pending_words.push_back(make_access(CMD_READ,  1, 0, 4, 32'h0));
    pending_words.push_back(make_access(CMD_WRITE, 1, 0, 4, 32'hFFFF_FFFF));
    pending_words.push_back(make_access(CMD_READ,  1, 0, 4, 32'h0));
    pending_words.push_back(make_access(CMD_WRITE, 1, 1, 1, 32'h0000_00A5));
    pending_words.push_back(make_access(CMD_READ,  1, 0, 4, 32'h0));
    pending_words.push_back(make_access(CMD_WRITE, NUM_SEGMENTS, SEG_BYTES-4, 4, 32'h1234_5678));
    pending_words.push_back(make_access(CMD_READ,  NUM_SEGMENTS, SEG_BYTES-4, 4, 32'h0));
    pending_words.push_back(make_access(CMD_READ,  NUM_SEGMENTS, SEG_BYTES-3, 4, 32'h0));
    pending_words.push_back(make_access(CMD_WRITE, NUM_SEGMENTS, SEG_BYTES-1, 2, 32'hFFFF));
    pending_words.push_back(make_access(CMD_WRITE, 2, SEG_BYTES-1, 1, 32'h0000_00AB));
    pending_words.push_back(make_access(CMD_READ,  0, 0, 4, 32'h0));
    pending_words.push_back(make_access(CMD_WRITE, NUM_SEGMENTS+1, 0, 4, 32'hCAFE_F00D));
    pending_words.push_back(make_access(CMD_WRITE, 15, 8, 2, 32'h5555_AAAA));
    pending_words.push_back(make_access(CMD_READ,  3, 0, 0, 32'h0));
    pending_words.push_back(make_access(CMD_WRITE, 3, 0, 5, 32'h1111_1111));
    pending_words.push_back(make_access(CMD_WRITE, 4, 0, 7, 32'h2222_2222));
    pending_words.push_back(make_access(CMD_READ,  4, 20'hF_FFFF, 1, 32'h0));
    pending_words.push_back(make_access(CMD_WRITE, 3, 10, 3, 32'hDEAD_BEEF, 8'hFF));
    pending_words.push_back(make_access(CMD_READ,  3, 10, 2, 32'h0, 8'hA5));
    pending_words.push_back(make_access(CMD_WRITE, 4, 256, 2, 32'h0000_0000));
    pending_words.push_back(make_access(CMD_READ,  4, 255, 4, 32'hFFFF_FFFF));
    pending_words.push_back(make_access(CMD_READ,  2, SEG_BYTES-4, 4, 32'h0));

    for (int i = 0; i < 2000; i++) begin
      if ($urandom_range(0, 99) < 78) begin
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
          ofs = $urandom_range(0, 63);
        end else if (pick == 2) begin
          ofs = $urandom_range(SEG_BYTES-8, SEG_BYTES-1);
        end else begin
          ofs = $urandom_range(0, SEG_BYTES-1);
        end
        a = make_access(1'($urandom_range(0, 1)), $urandom_range(1, NUM_SEGMENTS), ofs,
                        $urandom_range(1, MAX_ACCESS_BYTES), $urandom,
                        8'($urandom_range(0, 255)));
      end else begin
        a.command      = 1'($urandom_range(0, 1));
        a.address      = $urandom;
        a.access_bytes = NB_W'($urandom_range(0, 7));
        a.write_data   = $urandom;
      end
      pending_words.push_back(a);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/smb_pkg.sv
sv/smb_if.sv
sv/smb_ram.sv
sv/smb_decode.sv
sv/segmented_memory_with_bounds.sv
dv/tb_top.sv
